>>> hdl/assert_macros.svh
// Assertion macros shared by the cipher RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/xtea_pkg.sv
// Types, constants and the mix function of the XTEA cipher core.
// No dependencies; used by xtea_stage and xtea_block_cipher_core.
package xtea_pkg;

   localparam int unsigned DefaultRounds = 32;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned NumKeyWords   = 4;
   localparam int unsigned CsrIndexWidth = 8;
   localparam logic [63:0] Delta         = 64'h0000_0000_9e37_79b9;

   // register indexes of the key words
   localparam logic [CsrIndexWidth-1:0] KEY_WORD_0_IDX = 8'd0;
   localparam logic [CsrIndexWidth-1:0] KEY_WORD_1_IDX = 8'd1;
   localparam logic [CsrIndexWidth-1:0] KEY_WORD_2_IDX = 8'd2;
   localparam logic [CsrIndexWidth-1:0] KEY_WORD_3_IDX = 8'd3;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [NumKeyWords-1:0] key_type;

   typedef struct packed {
      logic     decipher;
      word_type block_low;
      word_type block_high;
   } req_type;

   typedef struct packed {
      word_type result_low;
      word_type result_high;
   } rsp_type;

   function automatic word_type mix(input word_type v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

>>> hdl/xtea_stage.sv
// One XTEA half-cycle with its pipeline register; the sum and key choice
// are fixed per stage and direction. Depends on xtea_pkg.
module xtea_stage #(
   parameter int unsigned ROUNDS = xtea_pkg::DefaultRounds,
   parameter int unsigned STAGE  = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  xtea_pkg::key_type key,
   input  logic             in_valid,
   input  xtea_pkg::req_type in_data,
   output logic             out_valid,
   output xtea_pkg::req_type out_data
);
   import xtea_pkg::*;

   localparam int unsigned Round = STAGE / 2;
   localparam int unsigned Half  = STAGE % 2;
   localparam logic [31:0] SumEnc = 32'(64'(Round + Half) * Delta);
   localparam logic [31:0] SumDec = 32'(64'(ROUNDS - Round - Half) * Delta);
   // encipher: first half updates the low word; decipher: second half does
   localparam logic UpdLowEnc = (Half == 0);
   localparam logic UpdLowDec = (Half == 1);
   localparam logic [1:0] KeyEncIdx = UpdLowEnc ? SumEnc[1:0] : SumEnc[12:11];
   localparam logic [1:0] KeyDecIdx = UpdLowDec ? SumDec[1:0] : SumDec[12:11];

   logic     valid_ff;
   req_type  data_ff;
   req_type  data_in;
   logic     update_low;
   word_type src;
   word_type dst;
   word_type sum;
   word_type key_word;
   word_type f;
   word_type dst_new;

   always_comb begin
      update_low = in_data.decipher ? UpdLowDec : UpdLowEnc;
      src        = update_low ? in_data.block_high : in_data.block_low;
      dst        = update_low ? in_data.block_low : in_data.block_high;
      sum        = in_data.decipher ? SumDec : SumEnc;
      key_word   = in_data.decipher ? key[KeyDecIdx] : key[KeyEncIdx];
      f          = mix(src) ^ (sum + key_word);
      dst_new    = in_data.decipher ? (dst - f) : (dst + f);
      data_in    = in_data;
      if (update_low) begin
         data_in.block_low = dst_new;
      end else begin
         data_in.block_high = dst_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hdl/xtea_block_cipher_core.sv
// Throughput: one block per cycle unless stalled; one register stage per XTEA half-cycle.
// The whole pipeline holds while a response waits under rsp_stall.
// Reset (synchronous, active high) clears all stage valid bits and the key
// words to zero.
module xtea_block_cipher_core #(
   parameter int unsigned ROUNDS = xtea_pkg::DefaultRounds
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  xtea_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output xtea_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [xtea_pkg::CsrIndexWidth-1:0] csr_index,
   input  xtea_pkg::word_type                 csr_wdata
);
   import xtea_pkg::*;

   `include "assert_macros.svh"

   localparam int unsigned NumStages = 2 * ROUNDS;

   key_type key_ff;
   logic    advance;
   logic    pipe_valid [NumStages+1];
   req_type pipe_data  [NumStages+1];
   logic [NumStages-1:0] stage_valid;

   // key registers; writes only land while the pipeline is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            KEY_WORD_0_IDX: key_ff[0] <= csr_wdata;
            KEY_WORD_1_IDX: key_ff[1] <= csr_wdata;
            KEY_WORD_2_IDX: key_ff[2] <= csr_wdata;
            KEY_WORD_3_IDX: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // no transaction in flight and none entering this cycle
   assign csr_ready = !(|stage_valid) && !req_valid;

   // global enable: everything moves unless the finished result is held
   assign advance   = !(pipe_valid[NumStages] && rsp_stall);
   assign req_stall = !advance;

   assign pipe_valid[0] = req_valid;
   assign pipe_data[0]  = req_data;

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      xtea_stage #(
         .ROUNDS (ROUNDS),
         .STAGE  (s)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key       (key_ff),
         .in_valid  (pipe_valid[s]),
         .in_data   (pipe_data[s]),
         .out_valid (pipe_valid[s+1]),
         .out_data  (pipe_data[s+1])
      );
      assign stage_valid[s] = pipe_valid[s+1];
   end

   assign rsp_valid            = pipe_valid[NumStages];
   assign rsp_data.result_low  = pipe_data[NumStages].block_low;
   assign rsp_data.result_high = pipe_data[NumStages].block_high;

   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, stage_valid[0])
   `ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_valid && rsp_stall, $stable(stage_valid))
   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, stage_valid == '0)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for xtea_block_cipher_core: XTEA encipher/decipher traffic
// against an in-bench cipher model, with random gaps, back-pressure and key rewrites.
// Depends on xtea_pkg and the core RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import xtea_pkg::*;

   localparam int unsigned CipherRounds = DefaultRounds;
   localparam int unsigned PipeLatency  = 2 * CipherRounds;
   localparam word_type    RoundDelta   = Delta[WordWidth-1:0];
   localparam logic [CsrIndexWidth-1:0] FIRST_SPARE_IDX = CsrIndexWidth'(NumKeyWords);
   localparam logic [CsrIndexWidth-1:0] LAST_SPARE_IDX  = '1;
   localparam int unsigned RandomPhases = 6;
   localparam int unsigned PhaseBlocks  = 130;
   localparam int unsigned DrainLimit   = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   word_type                 csr_wdata;

   word_type    key_model [NumKeyWords];
   rsp_type     expected_blocks [$];
   int          error_count;
   bit          tx_idling;
   bit          rx_idling;
   int unsigned hold_cycles;

   xtea_block_cipher_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic word_type feistel_f(input word_type v);
      word_type s;
      s = {v[WordWidth-5:0], 4'b0} ^ {5'b0, v[WordWidth-1:5]};
      return s + v;
   endfunction

   function automatic rsp_type cipher_result(input req_type blk);
      word_type v0;
      word_type v1;
      word_type total;
      rsp_type  res;
      v0 = blk.block_low;
      v1 = blk.block_high;
      if (!blk.decipher) begin
         total = '0;
         for (int r = 0; r < CipherRounds; r++) begin
            v0 = v0 + (feistel_f(v1) ^ (total + key_model[total[1:0]]));
            total = total + RoundDelta;
            v1 = v1 + (feistel_f(v0) ^ (total + key_model[total[12:11]]));
         end
      end else begin
         // sum starts at delta * rounds, wrapped to 32 bits
         total = word_type'(RoundDelta * CipherRounds);
         for (int r = 0; r < CipherRounds; r++) begin
            v1 = v1 - (feistel_f(v0) ^ (total + key_model[total[12:11]]));
            total = total - RoundDelta;
            v0 = v0 - (feistel_f(v1) ^ (total + key_model[total[1:0]]));
         end
      end
      res.result_low  = v0;
      res.result_high = v1;
      return res;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type random_word();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   function automatic req_type random_block();
      req_type blk;
      blk.decipher   = 1'($urandom_range(0, 1));
      blk.block_low  = random_word();
      blk.block_high = random_word();
      return blk;
   endfunction

   task automatic send_block(input req_type blk);
      int unsigned gap;
      gap = pick_gap(tx_idling);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_data  <= random_block();
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= blk;
      do @(posedge clock); while (req_stall);
      expected_blocks.push_back(cipher_result(blk));
   endtask

   task automatic send_fields(input bit dir, input word_type lo, input word_type hi);
      req_type blk;
      blk.decipher   = dir;
      blk.block_low  = lo;
      blk.block_high = hi;
      send_block(blk);
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input word_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NumKeyWords) key_model[idx[1:0]] = value;
   endtask

   // only called with the pipeline empty
   task automatic program_key(input word_type w0, input word_type w1,
                              input word_type w2, input word_type w3,
                              input bit stray_write);
      write_csr(KEY_WORD_0_IDX, w0);
      write_csr(KEY_WORD_1_IDX, w1);
      write_csr(KEY_WORD_2_IDX, w2);
      write_csr(KEY_WORD_3_IDX, w3);
      if (stray_write)
         write_csr(CsrIndexWidth'($urandom_range(FIRST_SPARE_IDX, LAST_SPARE_IDX)),
                   $urandom);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_edge_blocks();
      send_fields(1'b0, '0, '0);
      send_fields(1'b1, '0, '0);
      send_fields(1'b0, '1, '1);
      send_fields(1'b1, '1, '1);
   endtask

   task automatic test_reset_key();
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      send_edge_blocks();
      send_fields(1'b0, 32'h0123_4567, 32'h89ab_cdef);
      send_fields(1'b1, 32'h0123_4567, 32'h89ab_cdef);
      finish_phase();
   endtask

   task automatic test_key_extremes();
      program_key('1, '1, '1, '1, 1'b1);
      send_edge_blocks();
      finish_phase();
      program_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0a0b, 32'h0c0d_0e0f, 1'b0);
      send_fields(1'b0, 32'h4142_4344, 32'h4546_4748);
      send_fields(1'b1, 32'h4142_4344, 32'h4546_4748);
      finish_phase();
      // writes to unused indexes must leave the key alone
      write_csr(LAST_SPARE_IDX, '1);
      write_csr(FIRST_SPARE_IDX, 32'h5a5a_a5a5);
      @(negedge clock);
      csr_valid <= 1'b0;
      send_fields(1'b0, 32'haaaa_5555, 32'h5555_aaaa);
      send_fields(1'b1, 32'haaaa_5555, 32'h5555_aaaa);
      finish_phase();
   endtask

   task automatic test_random_traffic();
      int unsigned sent;
      req_type     blk;
      req_type     back;
      rsp_type     cipher;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         program_key(random_word(), random_word(), random_word(), random_word(),
                     1'($urandom_range(0, 1)));
         sent = 0;
         while (sent < PhaseBlocks) begin
            if (sent % 35 == 0) begin
               tx_idling = $urandom_range(0, 3) != 0;
               rx_idling = $urandom_range(0, 3) != 0;
            end
            blk = random_block();
            send_block(blk);
            sent++;
            // round trip: decipher what was just enciphered
            if (!blk.decipher && $urandom_range(0, 3) == 0) begin
               cipher          = cipher_result(blk);
               back.decipher   = 1'b1;
               back.block_low  = cipher.result_low;
               back.block_high = cipher.result_high;
               send_block(back);
               sent++;
            end
         end
         finish_phase();
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall the input
   task automatic test_backpressure();
      tx_idling   = 1'b0;
      rx_idling   = 1'b0;
      hold_cycles = 4 * PipeLatency;
      repeat (3 * PipeLatency) send_block(random_block());
      finish_phase();
   endtask

   task automatic test_sender_pause();
      tx_idling = 1'b1;
      rx_idling = 1'b1;
      repeat (30) send_block(random_block());
      finish_phase();
      repeat (30) send_block(random_block());
      finish_phase();
   endtask

   initial begin : receiver_stall
      int unsigned stall_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end else begin
            stall_left = pick_gap(rx_idling);
            if (stall_left != 0) begin
               rsp_stall <= 1'b1;
               stall_left = stall_left - 1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // one result transaction per accepted block, in order
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $error("result with no block outstanding: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_data.result_low !== want.result_low) begin
               $error("result_low: expected %h, got %h", want.result_low,
                      rsp_data.result_low);
               error_count++;
            end
            if (rsp_data.result_high !== want.result_high) begin
               $error("result_high: expected %h, got %h", want.result_high,
                      rsp_data.result_high);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned waited;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      tx_idling   = 1'b0;
      rx_idling   = 1'b0;
      hold_cycles = 0;
      error_count = 0;
      foreach (key_model[i]) key_model[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_key();
      test_key_extremes();
      test_random_traffic();
      test_backpressure();
      test_sender_pause();

      waited = 0;
      while (expected_blocks.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (PipeLatency + 16) @(posedge clock);
      if (expected_blocks.size() != 0) begin
         $error("%0d results never arrived", expected_blocks.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
